FILE: rtl/vplu_pkg.sv
package vplu_pkg;

    localparam int VECTOR_BYTES = 16;
    localparam int BYTE_W       = 8;
    localparam int HALF_W       = 64;
    localparam int SRC_BYTES    = 2 * VECTOR_BYTES;
    localparam int LANE_IDX_W   = $clog2(VECTOR_BYTES);
    localparam int SEL_W        = $clog2(SRC_BYTES);
    localparam int IMM_W        = 5;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        OP_VPERM  = 2'd0,
        OP_VXOR   = 2'd1,
        OP_VSPLAT = 2'd2,
        OP_LVSR   = 2'd3
    } op_t;

    // shared per-item control fanned out to every lane
    typedef struct packed {
        op_t                   op;
        byte_t                 splat;
        logic [LANE_IDX_W-1:0] shift;
    } lane_ctrl_t;

endpackage

FILE: rtl/vplu_lane.sv
module vplu_lane (
    input  vplu_pkg::lane_ctrl_t                  ctrl,
    input  vplu_pkg::byte_t                       src [vplu_pkg::SRC_BYTES],
    input  vplu_pkg::byte_t                       ctl_byte,
    input  logic [vplu_pkg::LANE_IDX_W-1:0]       lane_idx,
    output vplu_pkg::byte_t                       res
);
    import vplu_pkg::*;

    logic [SEL_W-1:0] sel;
    logic [SEL_W-1:0] b_idx;

    // control bits above the 32-byte range are ignored
    assign sel   = ctl_byte[SEL_W-1:0];
    assign b_idx = {1'b1, lane_idx};

    always_comb begin
        unique case (ctrl.op)
            OP_VPERM:  res = src[sel];
            OP_VXOR:   res = src[{1'b0, lane_idx}] ^ src[b_idx];
            OP_VSPLAT: res = ctrl.splat;
            OP_LVSR:   res = BYTE_W'(ctrl.shift) + BYTE_W'(lane_idx);
        endcase
    end

endmodule

FILE: rtl/vector_permute_logic_unit.sv
// 128-bit vector unit: permute, xor, splat immediate and load-shift-right
// control, chosen by s_op. Sixteen byte lanes work side by side and their
// bytes are merged into one output register, so an item is accepted every
// cycle while s_ready is high, and its result shows on the m_ side in the
// cycle after acceptance. s_ready drops only while a result is held in the
// output register and m_ready is low. Bytes are numbered big-endian: byte 0
// is the top byte of the hi half. No state is kept between items.
module vector_permute_logic_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_op,
    input  logic [vplu_pkg::HALF_W-1:0]    s_a_hi,
    input  logic [vplu_pkg::HALF_W-1:0]    s_a_lo,
    input  logic [vplu_pkg::HALF_W-1:0]    s_b_hi,
    input  logic [vplu_pkg::HALF_W-1:0]    s_b_lo,
    input  logic [vplu_pkg::HALF_W-1:0]    s_c_hi,
    input  logic [vplu_pkg::HALF_W-1:0]    s_c_lo,
    input  logic signed [vplu_pkg::IMM_W-1:0] s_imm,
    input  logic                           s_ra_is_zero,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [vplu_pkg::HALF_W-1:0]    m_vrt_hi,
    output logic [vplu_pkg::HALF_W-1:0]    m_vrt_lo
);
    import vplu_pkg::*;

    localparam int HALF_BYTES = VECTOR_BYTES / 2;

    byte_t      src      [SRC_BYTES];
    byte_t      ctl      [VECTOR_BYTES];
    byte_t      lane_res [VECTOR_BYTES];
    lane_ctrl_t ctrl;

    logic [2*HALF_W-1:0]   merged;
    logic [LANE_IDX_W-1:0] base_lo;

    logic              m_valid_reg,  m_valid_next;
    logic [HALF_W-1:0] m_vrt_hi_reg, m_vrt_hi_next;
    logic [HALF_W-1:0] m_vrt_lo_reg, m_vrt_lo_next;
    logic              s_fire;

    // unpack A || B and the control vector into big-endian byte arrays
    for (genvar k = 0; k < HALF_BYTES; k++) begin : g_unpack
        assign src[k]                           = s_a_hi[BYTE_W*(HALF_BYTES-1-k) +: BYTE_W];
        assign src[HALF_BYTES + k]              = s_a_lo[BYTE_W*(HALF_BYTES-1-k) +: BYTE_W];
        assign src[VECTOR_BYTES + k]            = s_b_hi[BYTE_W*(HALF_BYTES-1-k) +: BYTE_W];
        assign src[VECTOR_BYTES + HALF_BYTES + k] = s_b_lo[BYTE_W*(HALF_BYTES-1-k) +: BYTE_W];
        assign ctl[k]                           = s_c_hi[BYTE_W*(HALF_BYTES-1-k) +: BYTE_W];
        assign ctl[HALF_BYTES + k]              = s_c_lo[BYTE_W*(HALF_BYTES-1-k) +: BYTE_W];
    end

    // lvsr: only the low nibble of the address sum matters
    assign base_lo    = s_ra_is_zero ? '0 : s_a_lo[LANE_IDX_W-1:0];
    assign ctrl.op    = op_t'(s_op);
    assign ctrl.splat = BYTE_W'(s_imm);
    assign ctrl.shift = base_lo + s_b_lo[LANE_IDX_W-1:0];

    for (genvar g = 0; g < VECTOR_BYTES; g++) begin : g_lane
        vplu_lane u_lane (
            .ctrl     (ctrl),
            .src      (src),
            .ctl_byte (ctl[g]),
            .lane_idx (LANE_IDX_W'(g)),
            .res      (lane_res[g])
        );
        assign merged[BYTE_W*(VECTOR_BYTES-1-g) +: BYTE_W] = lane_res[g];
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_vrt_hi_next = m_vrt_hi_reg;
        m_vrt_lo_next = m_vrt_lo_reg;
        if (s_fire) begin
            m_valid_next  = 1'b1;
            m_vrt_hi_next = merged[2*HALF_W-1:HALF_W];
            m_vrt_lo_next = merged[HALF_W-1:0];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_vrt_hi_reg <= m_vrt_hi_next;
        m_vrt_lo_reg <= m_vrt_lo_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_vrt_hi = m_vrt_hi_reg;
    assign m_vrt_lo = m_vrt_lo_reg;

endmodule

FILE: rtl/vplu_checker.sv
module vplu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [1:0]                     s_op,
    input logic [vplu_pkg::HALF_W-1:0]    s_a_hi,
    input logic [vplu_pkg::HALF_W-1:0]    s_a_lo,
    input logic [vplu_pkg::HALF_W-1:0]    s_b_hi,
    input logic [vplu_pkg::HALF_W-1:0]    s_b_lo,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [vplu_pkg::HALF_W-1:0]    m_vrt_hi,
    input logic [vplu_pkg::HALF_W-1:0]    m_vrt_lo
);
    import vplu_pkg::*;

    // held result stays put until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vrt_hi) && $stable(m_vrt_lo))
        else $error("result changed while stalled");

    // each accepted item shows up the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item not presented");

    // never overwrite an untaken result
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input ready while result stalled");

    a_xor: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_VXOR) |=>
        (m_vrt_hi == $past(s_a_hi ^ s_b_hi)) && (m_vrt_lo == $past(s_a_lo ^ s_b_lo)))
        else $error("xor result mismatch");

    a_splat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_VSPLAT) |=> m_vrt_hi == m_vrt_lo)
        else $error("splat halves differ");

endmodule

bind vector_permute_logic_unit vplu_checker u_vplu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_op     (s_op),
    .s_a_hi   (s_a_hi),
    .s_a_lo   (s_a_lo),
    .s_b_hi   (s_b_hi),
    .s_b_lo   (s_b_lo),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_vrt_hi (m_vrt_hi),
    .m_vrt_lo (m_vrt_lo)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import vplu_pkg::*;

    typedef struct {
        op_t                      op;
        logic [HALF_W-1:0]        a_hi;
        logic [HALF_W-1:0]        a_lo;
        logic [HALF_W-1:0]        b_hi;
        logic [HALF_W-1:0]        b_lo;
        logic [HALF_W-1:0]        c_hi;
        logic [HALF_W-1:0]        c_lo;
        logic signed [IMM_W-1:0]  imm;
        logic                     ra_is_zero;
    } vec_instr_t;

    typedef struct {
        logic [HALF_W-1:0] vrt_hi;
        logic [HALF_W-1:0] vrt_lo;
    } vec_result_t;

    localparam logic [HALF_W-1:0] ONES      = {HALF_W{1'b1}};
    localparam logic [HALF_W-1:0] IDENT_HI  = 64'h0001020304050607;
    localparam logic [HALF_W-1:0] IDENT_LO  = 64'h08090A0B0C0D0E0F;
    localparam int                RANDOM_N  = 1800;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [1:0]                    s_op;
    logic [HALF_W-1:0]             s_a_hi;
    logic [HALF_W-1:0]             s_a_lo;
    logic [HALF_W-1:0]             s_b_hi;
    logic [HALF_W-1:0]             s_b_lo;
    logic [HALF_W-1:0]             s_c_hi;
    logic [HALF_W-1:0]             s_c_lo;
    logic signed [IMM_W-1:0]       s_imm;
    logic                          s_ra_is_zero;
    logic                          m_valid;
    logic                          m_ready;
    logic [HALF_W-1:0]             m_vrt_hi;
    logic [HALF_W-1:0]             m_vrt_lo;

    vec_instr_t  pending_instrs[$];
    vec_result_t expected_vectors[$];
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          mismatch_count;
    logic        s_took;

    vector_permute_logic_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_a_hi       (s_a_hi),
        .s_a_lo       (s_a_lo),
        .s_b_hi       (s_b_hi),
        .s_b_lo       (s_b_lo),
        .s_c_hi       (s_c_hi),
        .s_c_lo       (s_c_lo),
        .s_imm        (s_imm),
        .s_ra_is_zero (s_ra_is_zero),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_vrt_hi     (m_vrt_hi),
        .m_vrt_lo     (m_vrt_lo)
    );

    // byte 0 is the most significant byte of the hi half
    function automatic vec_result_t vector_unit_result(vec_instr_t it);
        vec_result_t           r;
        logic [4*HALF_W-1:0]   src;
        logic [2*HALF_W-1:0]   ctrl;
        logic [2*HALF_W-1:0]   res;
        logic [HALF_W-1:0]     addr;
        logic [SEL_W-1:0]      sel;
        logic [BYTE_W-1:0]     splat;
        logic [LANE_IDX_W-1:0] shift;
        src  = {it.a_hi, it.a_lo, it.b_hi, it.b_lo};
        ctrl = {it.c_hi, it.c_lo};
        res  = '0;
        case (it.op)
            OP_VPERM: begin
                for (int i = 0; i < VECTOR_BYTES; i++) begin
                    // low bits of control byte i
                    sel = ctrl[2*HALF_W-BYTE_W*(i+1) +: SEL_W];
                    res[2*HALF_W-1-BYTE_W*i -: BYTE_W] =
                        src[4*HALF_W-1-BYTE_W*sel -: BYTE_W];
                end
            end
            OP_VXOR: begin
                res = {it.a_hi ^ it.b_hi, it.a_lo ^ it.b_lo};
            end
            OP_VSPLAT: begin
                splat = {{(BYTE_W-IMM_W){it.imm[IMM_W-1]}}, it.imm};
                res   = {VECTOR_BYTES{splat}};
            end
            default: begin
                addr  = (it.ra_is_zero ? '0 : it.a_lo) + it.b_lo;
                shift = addr[LANE_IDX_W-1:0];
                for (int i = 0; i < VECTOR_BYTES; i++)
                    res[2*HALF_W-1-BYTE_W*i -: BYTE_W] = BYTE_W'(shift + i);
            end
        endcase
        r.vrt_hi = res[2*HALF_W-1:HALF_W];
        r.vrt_lo = res[HALF_W-1:0];
        return r;
    endfunction

    // random 64-bit operand, biased now and then to all zeros or all ones
    function automatic logic [HALF_W-1:0] rand_half();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return ONES;
        return {$urandom, $urandom};
    endfunction

    function automatic vec_instr_t rand_instr();
        vec_instr_t it;
        it.op         = op_t'($urandom_range(3));
        it.a_hi       = rand_half();
        it.a_lo       = rand_half();
        it.b_hi       = rand_half();
        it.b_lo       = rand_half();
        it.c_hi       = rand_half();
        it.c_lo       = rand_half();
        it.imm        = IMM_W'($urandom_range(31));
        it.ra_is_zero = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic add_instr(op_t op, logic [HALF_W-1:0] a_hi, logic [HALF_W-1:0] a_lo,
                             logic [HALF_W-1:0] b_hi, logic [HALF_W-1:0] b_lo,
                             logic [HALF_W-1:0] c_hi, logic [HALF_W-1:0] c_lo,
                             logic signed [IMM_W-1:0] imm, logic ra_is_zero);
        vec_instr_t it;
        it.op         = op;
        it.a_hi       = a_hi;
        it.a_lo       = a_lo;
        it.b_hi       = b_hi;
        it.b_lo       = b_lo;
        it.c_hi       = c_hi;
        it.c_lo       = c_lo;
        it.imm        = imm;
        it.ra_is_zero = ra_is_zero;
        pending_instrs.push_back(it);
    endtask

    // sender holds off until every item has gone through and come back
    task automatic wait_drained();
        while (pending_instrs.size() != 0 || s_valid || expected_vectors.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    // driver
    always @(negedge aclk) begin : drive_proc
        vec_instr_t nxt;
        if (s_valid && !s_took) begin
            // item still waiting for acceptance
        end else if (pending_instrs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            nxt = pending_instrs.pop_front();
            s_op         <= nxt.op;
            s_a_hi       <= nxt.a_hi;
            s_a_lo       <= nxt.a_lo;
            s_b_hi       <= nxt.b_hi;
            s_b_lo       <= nxt.b_lo;
            s_c_hi       <= nxt.c_hi;
            s_c_lo       <= nxt.c_lo;
            s_imm        <= nxt.imm;
            s_ra_is_zero <= nxt.ra_is_zero;
            s_valid      <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // monitor and checker
    always @(posedge aclk) begin : check_proc
        vec_instr_t  seen;
        vec_result_t want;
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            seen.op         = op_t'(s_op);
            seen.a_hi       = s_a_hi;
            seen.a_lo       = s_a_lo;
            seen.b_hi       = s_b_hi;
            seen.b_lo       = s_b_lo;
            seen.c_hi       = s_c_hi;
            seen.c_lo       = s_c_lo;
            seen.imm        = s_imm;
            seen.ra_is_zero = s_ra_is_zero;
            expected_vectors.push_back(vector_unit_result(seen));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_vectors.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result item with none expected: hi %h lo %h",
                             $realtime, m_vrt_hi, m_vrt_lo);
            end else begin
                want = expected_vectors.pop_front();
                if (m_vrt_hi !== want.vrt_hi || m_vrt_lo !== want.vrt_lo) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch: exp hi %h lo %h, got hi %h lo %h",
                                 $realtime, want.vrt_hi, want.vrt_lo, m_vrt_hi, m_vrt_lo);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = OP_VPERM;
        s_a_hi         = '0;
        s_a_lo         = '0;
        s_b_hi         = '0;
        s_b_lo         = '0;
        s_c_hi         = '0;
        s_c_lo         = '0;
        s_imm          = '0;
        s_ra_is_zero   = 1'b0;
        m_ready        = 1'b0;
        s_took         = 1'b0;
        mismatch_count = 0;
        snd_idle_pct   = 15;
        rcv_idle_pct   = 50;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // permute: straight from A, straight from B, high control bits set
        add_instr(OP_VPERM, rand_half(), rand_half(), rand_half(), rand_half(),
                  IDENT_HI, IDENT_LO, -5'sd16, 1'b0);
        add_instr(OP_VPERM, rand_half(), rand_half(), rand_half(), rand_half(),
                  IDENT_HI | 64'h1010101010101010, IDENT_LO | 64'h1010101010101010,
                  5'sd15, 1'b1);
        add_instr(OP_VPERM, rand_half(), rand_half(), rand_half(), rand_half(),
                  IDENT_HI | 64'hE0E0E0E0E0E0E0E0, IDENT_LO | 64'hE0E0E0E0E0E0E0E0,
                  5'sd0, 1'b0);
        add_instr(OP_VPERM, ONES, ONES, '0, rand_half(), ONES, ONES, -5'sd1, 1'b1);
        add_instr(OP_VPERM, ONES, ONES, '0, '0, '0, '0, 5'sd0, 1'b0);
        add_instr(OP_VPERM, IDENT_HI, IDENT_HI, ONES, '0,
                  IDENT_LO, 64'h1F1E1D1C1B1A1918,
                  5'sd7, 1'b1);
        // xor extremes
        add_instr(OP_VXOR, ONES, ONES, '0, '0, rand_half(), rand_half(), 5'sd3, 1'b0);
        add_instr(OP_VXOR, ONES, ONES, ONES, ONES, rand_half(), rand_half(), -5'sd9, 1'b1);
        add_instr(OP_VXOR, rand_half(), rand_half(), rand_half(), rand_half(), '0, '0,
                  5'sd0, 1'b0);
        // splat immediate extremes
        add_instr(OP_VSPLAT, rand_half(), rand_half(), rand_half(), rand_half(),
                  rand_half(), rand_half(), -5'sd16, 1'b0);
        add_instr(OP_VSPLAT, rand_half(), rand_half(), rand_half(), rand_half(),
                  rand_half(), rand_half(), 5'sd15, 1'b1);
        add_instr(OP_VSPLAT, ONES, ONES, ONES, ONES, ONES, ONES, 5'sd0, 1'b1);
        add_instr(OP_VSPLAT, '0, '0, '0, '0, '0, '0, -5'sd1, 1'b0);
        // shift-right control: zero base, sum wrap, base ignored
        add_instr(OP_LVSR, rand_half(), rand_half(), rand_half(), '0,
                  rand_half(), rand_half(), 5'sd1, 1'b1);
        add_instr(OP_LVSR, rand_half(), rand_half(), rand_half(), 64'hF,
                  rand_half(), rand_half(), 5'sd2, 1'b1);
        add_instr(OP_LVSR, rand_half(), ONES, rand_half(), 64'h1,
                  rand_half(), rand_half(), 5'sd0, 1'b0);
        add_instr(OP_LVSR, rand_half(), ONES, rand_half(), ONES,
                  rand_half(), rand_half(), -5'sd4, 1'b0);
        add_instr(OP_LVSR, rand_half(), ONES, rand_half(), 64'h5,
                  rand_half(), rand_half(), 5'sd9, 1'b1);
        add_instr(OP_LVSR, ONES, 64'h7, ONES, ONES, ONES, ONES, 5'sd11, 1'b0);
        add_instr(OP_LVSR, '0, '0, '0, '0, '0, '0, 5'sd0, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            snd_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 50 : 0;
            rcv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 15 : 0;
            for (int n = 0; n < RANDOM_N / 3; n++) begin
                pending_instrs.push_back(rand_instr());
                // mid-phase hold-off until the pipe is empty
                if (n == RANDOM_N / 6)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_vectors.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
